// ----- sv/bea_pkg.sv -----
// ----------------------------------------------------------------------------
// bea_pkg
// Types and constants shared by the button edge and auto-repeat block.
// ----------------------------------------------------------------------------
package bea_pkg;

  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_QUERY   = 2'd1;
  localparam logic [1:0] OP_ACK_ONE = 2'd2;
  localparam logic [1:0] OP_ACK_ALL = 2'd3;

  localparam logic [2:0] REG_START_DELAY = 3'd0;
  localparam logic [2:0] REG_SLOW        = 3'd1;
  localparam logic [2:0] REG_FAST        = 3'd2;
  localparam logic [2:0] REG_EXTRA       = 3'd3;
  localparam logic [2:0] REG_EXTRA_EN    = 3'd4;
  localparam logic [2:0] REG_REPEAT_MASK = 3'd5;

  localparam logic [1:0] SPEED_NONE  = 2'd0;
  localparam logic [1:0] SPEED_SLOW  = 2'd1;
  localparam logic [1:0] SPEED_FAST  = 2'd2;
  localparam logic [1:0] SPEED_EXTRA = 2'd3;

  localparam logic [15:0] RST_START_DELAY = 16'd3333;
  localparam logic [15:0] RST_SLOW        = 16'd3333;
  localparam logic [15:0] RST_FAST        = 16'd750;
  localparam logic [15:0] RST_EXTRA       = 16'd333;

  localparam logic [4:0] TALLY_MAX = 5'd31;

  // flags, lowest bit first: down, up, held, repeat, speed[1:0]
  typedef struct packed {
    logic [1:0] speed;
    logic       repeat_fired;
    logic       held;
    logic       up;
    logic       down;
  } flags_t;

  typedef struct packed {
    logic        last_level;
    flags_t      flags;
    logic        acked;
    logic [31:0] hold_accum;
    logic [31:0] deadline;
    logic [4:0]  repeat_tally;
    logic [31:0] held_tally;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [31:0] held_samples;
    logic [31:0] hold_duration;
    flags_t      flags;
  } result_t;

  typedef struct packed {
    logic [15:0] start_delay;
    logic [15:0] slow;
    logic [15:0] fast;
    logic [15:0] extra;
    logic        extra_en;
  } timing_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        in_range;
    logic        level;
    logic [15:0] dt;
    logic        ack_on_read;
    logic        repeat_en;
    logic        global_acked;
  } item_ctl_t;

endpackage

// ----- sv/button_edge_and_autorepeat.sv -----
// ----------------------------------------------------------------------------
// button_edge_and_autorepeat
// Per-button edge qualifier with accelerating auto-repeat and acknowledge.
// ----------------------------------------------------------------------------
// Each word passes through two states: the button's entry is read from the
// state RAM in the cycle the word is accepted (S_IDLE), then in S_EXEC it is
// updated, written back and the result word loaded into the output register.
// The RAM has a single registered read port. A result waiting at the output
// holds back the update of the following word, not its acceptance. Entries
// never written since reset read as the reset entry through a valid bit per
// button, so no clearing pass is needed. Exactly one result word per input word.
// ----------------------------------------------------------------------------
module button_edge_and_autorepeat import bea_pkg::*; #(
  parameter int BUTTON_COUNT    = 32,
  parameter int EXTRAFAST_AFTER = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // button[4:0], raw_level[5], input_off[6], dt_ticks[22:7], new_frame[23],
  // ack_on_read[24], zero[31:25]
  input  logic [31:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // flag_down[0], flag_up[1], flag_held[2], flag_repeat[3], repeat_speed[5:4],
  // hold_duration[37:6], held_samples[69:38], zero[71:70]
  output logic [71:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t           state;
  timing_t          timing;
  logic [31:0]      repeat_mask;
  logic             global_acked;
  logic             global_acked_next;
  logic [BUTTON_COUNT-1:0] valid;

  logic [1:0]       op;
  logic [4:0]       button;
  logic             level;
  logic [15:0]      dt;
  logic             new_frame;
  logic             ack_on_read;
  logic             in_range;
  logic [AW-1:0]    addr;

  logic             accept;
  logic             advance;
  logic [AW-1:0]    in_addr;
  logic [ENTRY_W-1:0] rd_data;
  entry_t           cur;
  entry_t           nxt;
  entry_t           rst_entry;
  item_ctl_t        ctl;
  result_t          res;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign advance   = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign in_addr   = AW'(s_tdata[4:0]);

  always_comb begin
    rst_entry          = '0;
    rst_entry.deadline = 32'(RST_START_DELAY);
  end

  assign cur = valid[addr] ? entry_t'(rd_data) : rst_entry;

  always_comb begin
    global_acked_next = global_acked;
    if (op == OP_SAMPLE && new_frame) begin
      global_acked_next = 1'b0;
    end
    if (op == OP_ACK_ALL) begin
      global_acked_next = 1'b1;
    end
  end

  always_comb begin
    ctl              = '0;
    ctl.op           = op;
    ctl.in_range     = in_range;
    ctl.level        = level;
    ctl.dt           = dt;
    ctl.ack_on_read  = ack_on_read;
    ctl.repeat_en    = repeat_mask[button];
    ctl.global_acked = global_acked_next;
  end

  bea_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BUTTON_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (advance && in_range),
    .waddr (addr),
    .wdata (nxt),
    .re    (accept),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  bea_update #(
    .EXTRAFAST_AFTER (EXTRAFAST_AFTER)
  ) u_update (
    .cur    (cur),
    .ctl    (ctl),
    .timing (timing),
    .nxt    (nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.start_delay <= RST_START_DELAY;
      timing.slow        <= RST_SLOW;
      timing.fast        <= RST_FAST;
      timing.extra       <= RST_EXTRA;
      timing.extra_en    <= 1'b1;
      repeat_mask        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_DELAY: timing.start_delay <= cfg_data[15:0];
        REG_SLOW:        timing.slow        <= cfg_data[15:0];
        REG_FAST:        timing.fast        <= cfg_data[15:0];
        REG_EXTRA:       timing.extra       <= cfg_data[15:0];
        REG_EXTRA_EN:    timing.extra_en    <= cfg_data[0];
        REG_REPEAT_MASK: repeat_mask        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= s_tuser;
      button      <= s_tdata[4:0];
      level       <= s_tdata[5] && !s_tdata[6];
      dt          <= s_tdata[22:7];
      new_frame   <= s_tdata[23];
      ack_on_read <= s_tdata[24];
      in_range    <= (int'(s_tdata[4:0]) < BUTTON_COUNT);
      addr        <= in_addr;
    end
    if (advance) begin
      m_tdata <= {2'b00, res};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      global_acked <= 1'b0;
      valid        <= '0;
    end else begin
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (advance) begin
            state        <= S_IDLE;
            global_acked <= global_acked_next;
            if (in_range) begin
              valid[addr] <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/bea_ram.sv -----
// ----------------------------------------------------------------------------
// bea_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/bea_update.sv -----
// ----------------------------------------------------------------------------
// bea_update
// Combinational update of one button entry: edges, hold time, repeat deadline, acknowledge, result.
// ----------------------------------------------------------------------------
module bea_update import bea_pkg::*; #(
  parameter int EXTRAFAST_AFTER = 16
) (
  input  entry_t    cur,
  input  item_ctl_t ctl,
  input  timing_t   timing,
  output entry_t    nxt,
  output result_t   res
);

  logic        prev;
  logic [32:0] hold_sum;
  logic [32:0] held_sum;
  logic [32:0] dl_sum;
  logic [4:0]  tally_inc;
  logic [15:0] step;
  logic [1:0]  speed;
  logic        visible;

  always_comb begin
    nxt       = cur;
    prev      = cur.last_level;
    hold_sum  = 33'(cur.hold_accum) + 33'(ctl.dt);
    held_sum  = 33'(cur.held_tally) + 33'd1;
    tally_inc = (cur.repeat_tally == TALLY_MAX) ? TALLY_MAX : cur.repeat_tally + 5'd1;
    step      = timing.slow;
    speed     = SPEED_SLOW;
    dl_sum    = '0;
    visible   = 1'b0;
    res       = '0;

    if (tally_inc > 5'(EXTRAFAST_AFTER) && timing.extra_en) begin
      step  = timing.extra;
      speed = SPEED_EXTRA;
    end else if (tally_inc > 5'd1) begin
      step  = timing.fast;
      speed = SPEED_FAST;
    end
    dl_sum = 33'(cur.deadline) + 33'(step);

    if (ctl.op == OP_SAMPLE) begin
      nxt.last_level = ctl.level;
      nxt.flags      = '0;
      if (ctl.level != prev) begin
        nxt.acked        = 1'b0;
        nxt.flags.down   = ctl.level;
        nxt.flags.up     = ~ctl.level;
        nxt.hold_accum   = '0;
        nxt.repeat_tally = '0;
        nxt.deadline     = 32'(timing.start_delay);
        nxt.held_tally   = '0;
      end
      if (ctl.level && prev) begin
        nxt.flags.held = 1'b1;
        nxt.hold_accum = hold_sum[32] ? '1 : hold_sum[31:0];
        nxt.held_tally = held_sum[32] ? '1 : held_sum[31:0];
        if (ctl.repeat_en && nxt.hold_accum >= cur.deadline) begin
          nxt.flags.repeat_fired = 1'b1;
          nxt.flags.speed        = speed;
          nxt.acked              = 1'b0;
          nxt.repeat_tally       = tally_inc;
          nxt.deadline           = dl_sum[32] ? '1 : dl_sum[31:0];
        end
      end
    end

    if (ctl.op == OP_ACK_ONE) begin
      nxt.acked = 1'b1;
    end

    visible = ctl.in_range && !ctl.global_acked && !nxt.acked;
    if (visible) begin
      res.flags         = nxt.flags;
      res.hold_duration = nxt.hold_accum;
    end
    if (ctl.in_range) begin
      res.held_samples = nxt.held_tally;
    end

    if (ctl.op == OP_QUERY && ctl.ack_on_read && res.flags != '0) begin
      nxt.acked = 1'b1;
    end
  end

endmodule
